FILE: src/mdfs_pkg.sv
// ----------------------------------------------------------------------------
// Maze DFS solver package
// Shared types, constants and helpers for the maze depth-first solver.
// ----------------------------------------------------------------------------
package mdfs_pkg;

  localparam int MAX_COLS_DEF = 64;
  localparam int MAX_ROWS_DEF = 64;

  // Request codes
  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_SOLVE = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;   // unknown request, acts as a read

  // Cell codes
  localparam logic [1:0] CODE_WALL    = 2'd0;
  localparam logic [1:0] CODE_OPEN    = 2'd1;
  localparam logic [1:0] CODE_PATH    = 2'd2;
  localparam logic [1:0] CODE_VISITED = 2'd3;

  // Result status codes
  localparam logic [2:0] ST_WRITTEN = 3'd0;
  localparam logic [2:0] ST_EXIT    = 3'd1;
  localparam logic [2:0] ST_NOEXIT  = 3'd2;
  localparam logic [2:0] ST_INVALID = 3'd3;
  localparam logic [2:0] ST_READ    = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SEED   = 2'd2;

  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ACCESS,   // read of the requested cell in flight
    S_START,    // check start cell
    S_NBR_RD,   // issue neighbor reads
    S_NBR_EVAL, // last neighbor data arrives
    S_MOD,      // reduce lfsr modulo count
    S_MOVE,     // enter picked neighbor
    S_POP_RD,   // stack top read in flight
    S_POP,      // new current from stack
    S_CHECK,    // border test
    S_OUT       // result held
  } state_t;

  // Galois step, shift right
  function automatic logic [15:0] lfsr_next(input logic [15:0] v);
    lfsr_next = v[0] ? ((v >> 1) ^ LFSR_TAPS) : (v >> 1);
  endfunction

endpackage

FILE: src/maze_random_dfs_solver.sv
// ----------------------------------------------------------------------------
// Maze random DFS solver
// A solve runs move and backtrack steps over one read port on the maze memory
// (four neighbor reads a step) and one stack memory. One item at a time; a new
// item is accepted only once the result has been taken.
// Reset: synchronous, active low; registers load 64, 64 and seed 1, the maze
// and stack memories are not cleared.
// ----------------------------------------------------------------------------
module maze_random_dfs_solver #(
  parameter int MAX_COLS = mdfs_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS = mdfs_pkg::MAX_ROWS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] req_type, [7:2] pos_x, [13:8] pos_y, [15:14] cell_in
  input  logic [15:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [2:0] status, [8:3] end_x, [14:9] end_y, [16:15] cell_out
  output logic [23:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int XW     = $clog2(MAX_COLS);
  localparam int YW     = $clog2(MAX_ROWS);
  localparam int AW     = XW + YW;
  localparam int CELLS  = MAX_COLS * MAX_ROWS;
  localparam int MDEPTH = 1 << AW;
  localparam int DW     = AW + 1;

  // Configuration registers
  logic [6:0]  gw_r, gh_r;
  logic [15:0] seed_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= 7'd64; gh_r <= 7'd64; seed_r <= 16'd1;
    end else if (cfg_valid) begin
      if (cfg_index == mdfs_pkg::CFG_WIDTH)  gw_r <= cfg_data[6:0];
      if (cfg_index == mdfs_pkg::CFG_HEIGHT) gh_r <= cfg_data[6:0];
      if (cfg_index == mdfs_pkg::CFG_SEED)   seed_r <= cfg_data;
    end
  end

  // Effective sizes, widened to 9 bits
  logic [8:0] w_eff, h_eff;
  always_comb begin
    if (gw_r == 7'd0) w_eff = 9'd1;
    else if (32'(gw_r) > MAX_COLS) w_eff = 9'(MAX_COLS);
    else w_eff = {2'b0, gw_r};
    if (gh_r == 7'd0) h_eff = 9'd1;
    else if (32'(gh_r) > MAX_ROWS) h_eff = 9'(MAX_ROWS);
    else h_eff = {2'b0, gh_r};
  end

  // Memories
  logic [1:0]    maze_mem [MDEPTH];
  logic [AW-1:0] stack_mem [CELLS];
  logic          m_we, s_we;
  logic [AW-1:0] m_waddr, m_raddr, s_addr, s_wdata;
  logic [1:0]    m_wdata, m_rdata;
  logic [AW-1:0] s_rdata;
  always_ff @(posedge clk) begin
    if (m_we) maze_mem[m_waddr] <= m_wdata;
    m_rdata <= maze_mem[m_raddr];
  end
  always_ff @(posedge clk) begin
    if (s_we) stack_mem[s_addr] <= s_wdata;
    s_rdata <= stack_mem[s_addr];
  end

  // Item fields
  logic [1:0] req_r, code_r;
  logic [5:0] px_r, py_r;
  logic       in_store_r;

  mdfs_pkg::state_t state_r, state_nxt;
  logic [XW-1:0] cx_r, cx_nxt;
  logic [YW-1:0] cy_r, cy_nxt;
  logic [DW-1:0] depth_r, depth_nxt;
  logic [15:0]   lfsr_r, lfsr_nxt;
  logic [1:0]    k_r, k_nxt;          // neighbor read index
  logic [3:0]    kv_r, kv_nxt;        // neighbor direction issued last cycle valid
  logic [3:0]    open_r, open_nxt;    // open neighbors
  logic [1:0]    pick_r, pick_nxt;
  logic [15:0]   rem_r, rem_nxt;
  logic [2:0]    st_r, st_nxt;
  logic [5:0]    ox_r, ox_nxt, oy_r, oy_nxt;
  logic [1:0]    co_r, co_nxt;

  // Whether the neighbor in direction d (left, right, up, down) lies inside the maze
  function automatic logic nb_ok(input logic [1:0] d, input logic [8:0] x,
                                 input logic [8:0] y, input logic [8:0] w,
                                 input logic [8:0] h);
    unique case (d)
      2'd0: nb_ok = x != 9'd0;
      2'd1: nb_ok = (x + 9'd1) < w;
      2'd2: nb_ok = y != 9'd0;
      default: nb_ok = (y + 9'd1) < h;
    endcase
  endfunction

  // Remainder of v by a count of 1 to 4; base-4 digit sums give mod 3
  function automatic logic [1:0] mod_small(input logic [15:0] v, input logic [2:0] n);
    logic [4:0] s;
    logic [2:0] t, u;
    s = 5'(v[1:0]) + 5'(v[3:2]) + 5'(v[5:4]) + 5'(v[7:6]) +
        5'(v[9:8]) + 5'(v[11:10]) + 5'(v[13:12]) + 5'(v[15:14]);
    t = 3'(s[1:0]) + 3'(s[3:2]) + 3'(s[4]);
    u = 3'(t[1:0]) + 3'(t[2]);
    unique case (n)
      3'd1: mod_small = 2'd0;
      3'd2: mod_small = {1'b0, v[0]};
      3'd3: mod_small = (u >= 3'd3) ? 2'(u - 3'd3) : u[1:0];
      default: mod_small = v[1:0];
    endcase
  endfunction

  logic [8:0]    cx9, cy9;
  logic [XW-1:0] nbx;
  logic [YW-1:0] nby;
  logic [2:0]    n_cnt;
  logic [1:0]    sel_dir;
  logic [AW-1:0] cur_addr;
  assign cx9 = 9'(cx_r);
  assign cy9 = 9'(cy_r);
  assign cur_addr = {cy_r, cx_r};
  assign n_cnt = 3'(open_nxt[0]) + 3'(open_nxt[1]) + 3'(open_nxt[2]) + 3'(open_nxt[3]);

  always_comb begin
    nbx = cx_r; nby = cy_r;
    unique case (k_r)
      2'd0: nbx = cx_r - XW'(1);
      2'd1: nbx = cx_r + XW'(1);
      2'd2: nby = cy_r - YW'(1);
      default: nby = cy_r + YW'(1);
    endcase
  end

  // Select the pick_r-th set bit of open_r
  always_comb begin
    logic [1:0] c;
    c = 2'd0; sel_dir = 2'd0;
    for (int d = 0; d < 4; d++) begin
      if (open_r[d]) begin
        if (c == pick_r) sel_dir = 2'(d);
        c = c + 2'd1;
      end
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mdfs_pkg::S_IDLE:   if (in_tvalid) state_nxt = mdfs_pkg::S_ACCESS;
      mdfs_pkg::S_ACCESS:
        state_nxt = (req_r == mdfs_pkg::REQ_WRITE) ? mdfs_pkg::S_OUT : mdfs_pkg::S_START;
      mdfs_pkg::S_START:
        state_nxt = (req_r != mdfs_pkg::REQ_SOLVE || st_nxt == mdfs_pkg::ST_INVALID) ?
                    mdfs_pkg::S_OUT : mdfs_pkg::S_NBR_RD;
      mdfs_pkg::S_NBR_RD: if (k_r == 2'd3) state_nxt = mdfs_pkg::S_NBR_EVAL;
      mdfs_pkg::S_NBR_EVAL: state_nxt = (n_cnt != 3'd0) ? mdfs_pkg::S_MOD : mdfs_pkg::S_POP_RD;
      mdfs_pkg::S_MOD:    state_nxt = mdfs_pkg::S_MOVE;
      mdfs_pkg::S_MOVE:   state_nxt = mdfs_pkg::S_CHECK;
      mdfs_pkg::S_POP_RD: state_nxt = (depth_r == DW'(1)) ? mdfs_pkg::S_OUT : mdfs_pkg::S_POP;
      mdfs_pkg::S_POP:    state_nxt = mdfs_pkg::S_CHECK;
      mdfs_pkg::S_CHECK:  state_nxt = (st_nxt == mdfs_pkg::ST_EXIT) ?
                                      mdfs_pkg::S_OUT : mdfs_pkg::S_NBR_RD;
      mdfs_pkg::S_OUT:    if (out_tready) state_nxt = mdfs_pkg::S_IDLE;
      default:            state_nxt = mdfs_pkg::S_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    cx_nxt = cx_r; cy_nxt = cy_r; depth_nxt = depth_r; lfsr_nxt = lfsr_r;
    k_nxt = k_r; kv_nxt = kv_r; open_nxt = open_r; pick_nxt = pick_r; rem_nxt = rem_r;
    st_nxt = st_r; ox_nxt = ox_r; oy_nxt = oy_r; co_nxt = co_r;
    m_we = 1'b0; m_waddr = cur_addr; m_wdata = mdfs_pkg::CODE_PATH;
    m_raddr = {YW'(py_r), XW'(px_r)};
    s_we = 1'b0; s_addr = AW'(depth_r); s_wdata = cur_addr;
    unique case (state_r)
      mdfs_pkg::S_IDLE: begin
        // load result defaults from the accepted item
        if (in_tvalid) begin
          ox_nxt = in_tdata[7:2]; oy_nxt = in_tdata[13:8]; co_nxt = 2'd0;
          st_nxt = (in_tdata[1:0] == mdfs_pkg::REQ_WRITE) ? mdfs_pkg::ST_WRITTEN :
                   (in_tdata[1:0] == mdfs_pkg::REQ_SOLVE) ? mdfs_pkg::ST_NOEXIT :
                                                            mdfs_pkg::ST_READ;
        end
      end
      mdfs_pkg::S_ACCESS: begin
        if (req_r == mdfs_pkg::REQ_WRITE) begin
          m_we = in_store_r; m_waddr = {YW'(py_r), XW'(px_r)}; m_wdata = code_r;
        end
      end
      mdfs_pkg::S_START: begin
        if (req_r != mdfs_pkg::REQ_SOLVE) begin
          st_nxt = st_r;
        end else if (!in_store_r || 9'(px_r) >= w_eff || 9'(py_r) >= h_eff ||
                     m_rdata != mdfs_pkg::CODE_OPEN) begin
          st_nxt = mdfs_pkg::ST_INVALID;
        end else begin
          lfsr_nxt = (seed_r == 16'd0) ? 16'd1 : seed_r;
          cx_nxt = XW'(px_r); cy_nxt = YW'(py_r);
          m_we = 1'b1; m_waddr = {YW'(py_r), XW'(px_r)};
          s_we = 1'b1; s_addr = '0; s_wdata = {YW'(py_r), XW'(px_r)};
          depth_nxt = DW'(1);
          k_nxt = 2'd0; open_nxt = 4'd0;
        end
      end
      mdfs_pkg::S_NBR_RD, mdfs_pkg::S_NBR_EVAL: begin
        // read neighbor k, collect result of previous read
        m_raddr = {nby, nbx};
        if (state_r == mdfs_pkg::S_NBR_RD) begin
          kv_nxt[k_r] = nb_ok(k_r, cx9, cy9, w_eff, h_eff);
          k_nxt = k_r + 2'd1;
        end
        if (state_r == mdfs_pkg::S_NBR_EVAL || k_r != 2'd0) begin
          open_nxt[k_r - 2'd1] = kv_r[k_r - 2'd1] && (m_rdata == mdfs_pkg::CODE_OPEN);
        end
        // advance the lfsr only when there is a neighbor to pick
        if (state_r == mdfs_pkg::S_NBR_EVAL && n_cnt != 3'd0) begin
          lfsr_nxt = mdfs_pkg::lfsr_next(lfsr_r);
          rem_nxt = mdfs_pkg::lfsr_next(lfsr_r);
        end
      end
      mdfs_pkg::S_MOD: begin
        // count is 1 to 4
        pick_nxt = mod_small(rem_r, n_cnt);
      end
      mdfs_pkg::S_MOVE: begin
        unique case (sel_dir)
          2'd0: cx_nxt = cx_r - XW'(1);
          2'd1: cx_nxt = cx_r + XW'(1);
          2'd2: cy_nxt = cy_r - YW'(1);
          default: cy_nxt = cy_r + YW'(1);
        endcase
        m_we = 1'b1; m_waddr = {cy_nxt, cx_nxt};
        if (32'(depth_r) < CELLS) begin
          s_we = 1'b1; s_wdata = {cy_nxt, cx_nxt}; depth_nxt = depth_r + DW'(1);
        end
      end
      mdfs_pkg::S_POP_RD: begin
        m_we = 1'b1; m_wdata = mdfs_pkg::CODE_VISITED;
        depth_nxt = depth_r - DW'(1);
        s_addr = AW'(depth_r - DW'(2));
        if (depth_r == DW'(1)) begin
          st_nxt = mdfs_pkg::ST_NOEXIT;
        end
      end
      mdfs_pkg::S_POP: begin
        cx_nxt = s_rdata[XW-1:0]; cy_nxt = s_rdata[AW-1:XW];
      end
      mdfs_pkg::S_CHECK: begin
        k_nxt = 2'd0;
        if (cx_r == '0 || cy_r == '0 || cx9 == w_eff - 9'd1 || cy9 == h_eff - 9'd1) begin
          st_nxt = mdfs_pkg::ST_EXIT; ox_nxt = 6'(cx_r); oy_nxt = 6'(cy_r);
        end
      end
      default: ;
    endcase
  end

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mdfs_pkg::S_IDLE;
      depth_r <= '0; lfsr_r <= 16'd1; cx_r <= '0; cy_r <= '0;
      k_r <= '0; kv_r <= '0; open_r <= '0;
    end else begin
      state_r <= state_nxt;
      depth_r <= depth_nxt; lfsr_r <= lfsr_nxt; cx_r <= cx_nxt; cy_r <= cy_nxt;
      k_r <= k_nxt; kv_r <= kv_nxt; open_r <= open_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r <= pick_nxt; rem_r <= rem_nxt;
    st_r <= st_nxt; ox_r <= ox_nxt; oy_r <= oy_nxt; co_r <= co_nxt;
    if (state_r == mdfs_pkg::S_IDLE && in_tvalid) begin
      req_r <= in_tdata[1:0]; px_r <= in_tdata[7:2]; py_r <= in_tdata[13:8];
      code_r <= in_tdata[15:14];
      in_store_r <= (32'(in_tdata[7:2]) < MAX_COLS) && (32'(in_tdata[13:8]) < MAX_ROWS);
    end
  end

  // Read data addressed in S_ACCESS is valid in S_START, where it is captured
  logic [1:0] cell_q;
  always_ff @(posedge clk) begin
    if (state_r == mdfs_pkg::S_START) cell_q <= in_store_r ? m_rdata : 2'd0;
  end

  assign in_tready  = (state_r == mdfs_pkg::S_IDLE);
  assign out_tvalid = (state_r == mdfs_pkg::S_OUT);
  assign out_tdata  = {7'd0, (st_r == mdfs_pkg::ST_READ) ? cell_q : co_r, oy_r, ox_r, st_r};

endmodule
